// ===== rtl/olt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg: shared types for the ordered list table engine
// Operation and status codes, sequencer states and the result beat layout.
// ----------------------------------------------------------------------------
package olt_pkg;

	// Field widths fixed by the item layout
	localparam int unsigned ModeW  = 3;
	localparam int unsigned PosW   = 4;
	localparam int unsigned DataW  = 32;
	localparam int unsigned StatW  = 2;
	localparam int unsigned CountW = 5;

	// Operation codes carried by the mode field
	typedef enum logic [ModeW-1:0] {
		MODE_APPEND     = 3'd0,
		MODE_REMOVE_AT  = 3'd1,
		MODE_READ       = 3'd2,
		MODE_FIND       = 3'd3,
		MODE_CLEAR      = 3'd4,
		MODE_REMOVE_ALL = 3'd5
	} mode_t;

	// Result status codes
	typedef enum logic [StatW-1:0] {
		STAT_OK        = 2'd0,
		STAT_RANGE     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// One result beat as produced by the sequencer
	typedef struct packed {
		logic                vld;
		status_t             status;
		logic [DataW-1:0]    rdata;
		logic [PosW-1:0]     found;
		logic [CountW-1:0]   count;
		logic                empty;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/ordered_list_table_engine_top.sv =====
`default_nettype none
// Latency: append, clear, unused codes and rejected operations give their result
//   beat in the cycle after the command beat and never raise busy.
// Read, find, remove-at and remove-all raise busy and walk the entry RAM
//   one entry a cycle through the RAM read port, then drain the read stage;
//   the result beat appears in the same cycle that busy drops and is never held.
// Reset empties the list at once; the entry RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// ordered_list_table_engine_top: bounded ordered list of signed words
// Entry RAM, list sequencer and the registered result port.
// ----------------------------------------------------------------------------
module ordered_list_table_engine_top #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [olt_pkg::ModeW-1:0]          mode,
	input  wire logic [olt_pkg::PosW-1:0]           position,
	input  wire logic signed [olt_pkg::DataW-1:0]   value,
	output logic                                    done,
	output logic [olt_pkg::StatW-1:0]               status,
	output logic signed [olt_pkg::DataW-1:0]        read_value,
	output logic [olt_pkg::PosW-1:0]                found_position,
	output logic [olt_pkg::CountW-1:0]              count,
	output logic                                    is_empty
);

	import olt_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);

	logic               wr_en, rd_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [DataW-1:0]   wr_data, rd_data;
	res_t               res;
	logic               done_q;
	res_t               res_q;

	// entry storage
	olt_ram #(
		.WIDTH (DataW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer and compare unit
	olt_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.position (position),
		.value    (value),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.res      (res)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			res_q <= res;
		end
	end

	assign done           = done_q;
	assign status         = res_q.status;
	assign read_value     = res_q.rdata;
	assign found_position = res_q.found;
	assign count          = res_q.count;
	assign is_empty       = res_q.empty;

endmodule
`default_nettype wire

// ===== rtl/olt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module olt_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/olt_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// olt_seq: list sequencer and shared compare unit
// Keeps the fill count, decodes operations and walks the entry RAM one
// entry a cycle for read, find, remove-at and remove-all compaction.
// ----------------------------------------------------------------------------
module olt_seq #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// command side
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [olt_pkg::ModeW-1:0]      mode,
	input  wire logic [olt_pkg::PosW-1:0]       position,
	input  wire logic [olt_pkg::DataW-1:0]      value,
	// entry RAM
	output logic                                wr_en,
	output logic [$clog2(CAPACITY)-1:0]         wr_addr,
	output logic [olt_pkg::DataW-1:0]           wr_data,
	output logic                                rd_en,
	output logic [$clog2(CAPACITY)-1:0]         rd_addr,
	input  wire logic [olt_pkg::DataW-1:0]      rd_data,
	// result beat
	output olt_pkg::res_t                       res
);

	import olt_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > PosW) ? CW : PosW;

	state_t             state_q, state_d;
	mode_t              op_q;
	mode_t              mode_in;
	logic [DataW-1:0]   val_q;
	logic [PosW-1:0]    pos_q;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      r_q, w_q, end_q;
	logic [CW-1:0]      r_init, end_init;
	logic               vld_s1;
	logic [CW-1:0]      idx_s1;
	logic [DataW-1:0]   rd_q;

	logic               accept, walk_go;
	logic               in_range, full;
	logic               issue, hit, keep, walk_done;

	assign mode_in  = mode_t'(mode);
	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign in_range = PW'(position) < PW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));

	// shared compare unit on the data coming back from the RAM
	assign hit  = vld_s1 && (op_q == MODE_FIND) && (rd_data == val_q);
	assign keep = vld_s1 &&
		(((op_q == MODE_REMOVE_AT) && (PW'(idx_s1) != PW'(pos_q))) ||
		 ((op_q == MODE_REMOVE_ALL) && (rd_data != val_q)));

	// read pointer runs ahead of the data stage by one
	assign issue     = (state_q == ST_WALK) && (r_q < end_q) && !hit;
	assign walk_done = (state_q == ST_WALK) && (hit || ((r_q >= end_q) && !vld_s1));

	assign rd_en   = issue;
	assign rd_addr = r_q[AW-1:0];

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM writes and result
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		walk_go  = 1'b0;
		r_init   = '0;
		end_init = count_q;
		wr_en    = 1'b0;
		wr_addr  = w_q[AW-1:0];
		wr_data  = rd_data;
		res      = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res.vld    = 1'b1;
					res.status = STAT_OK;
					unique case (mode_in)
						MODE_APPEND: begin
							if (full) begin
								res.status = STAT_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = count_q[AW-1:0];
								wr_data = value;
								count_d = count_q + CW'(1);
							end
						end
						MODE_REMOVE_AT: begin
							if (!in_range) begin
								res.status = STAT_RANGE;
							end else begin
								res.vld = 1'b0;
								walk_go = 1'b1;
								r_init  = CW'(position);
							end
						end
						MODE_READ: begin
							if (!in_range) begin
								res.status = STAT_RANGE;
							end else begin
								res.vld  = 1'b0;
								walk_go  = 1'b1;
								r_init   = CW'(position);
								end_init = CW'(position) + CW'(1);
							end
						end
						MODE_FIND, MODE_REMOVE_ALL: begin
							res.vld = 1'b0;
							walk_go = 1'b1;
						end
						MODE_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
					if (walk_go) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				// compaction write of a surviving entry
				if (keep) begin
					wr_en = 1'b1;
				end
				if (walk_done) begin
					state_d    = ST_IDLE;
					res.vld    = 1'b1;
					res.status = STAT_OK;
					case (op_q)
						MODE_READ: begin
							res.rdata = rd_q;
						end
						MODE_FIND: begin
							if (hit) begin
								res.found = PosW'(idx_s1);
							end else begin
								res.status = STAT_NOT_FOUND;
							end
						end
						default: begin
							count_d = w_q;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		res.count = CountW'(count_d);
		res.empty = (count_d == '0);
	end

	// fill count and data stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			count_q <= count_d;
			vld_s1  <= issue;
		end
	end

	// walk pointers and operation registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= mode_in;
			val_q <= value;
			pos_q <= position;
			r_q   <= r_init;
			w_q   <= r_init;
			end_q <= end_init;
		end else begin
			if (issue) begin
				r_q <= r_q + CW'(1);
			end
			if (keep) begin
				w_q <= w_q + CW'(1);
			end
		end
		idx_s1 <= r_q;
		if (vld_s1 && (op_q == MODE_READ)) begin
			rd_q <= rd_data;
		end
	end

endmodule
`default_nettype wire
